// ===== hw/rtl/circle_masked_brightness_assert.svh =====
// Assertion macros for the checker file of circle_masked_brightness.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef CIRCLE_MASKED_BRIGHTNESS_ASSERT_SVH
`define CIRCLE_MASKED_BRIGHTNESS_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define CMB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define CMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cmb_pkg.sv =====
// Types and constants shared by the circle_masked_brightness modules.
// No dependencies.
package cmb_pkg;

    localparam int CMB_ADDR_W   = 5;
    localparam int CMB_DATA_W   = 32;
    localparam int DIFF_W       = 16;   // signed column/row offset
    localparam int WCMP_W       = 15;   // width comparisons
    localparam int SQ_OP_W      = 13;
    localparam int SQ_PROD_W    = 26;
    localparam int DIST_W       = 27;
    localparam int SUM_W        = 32;
    localparam int COUNT_W      = 25;
    localparam int FRAC_W       = 17;
    localparam int DIVIDEND_W   = 48;
    localparam int DIVISOR_W    = 33;
    localparam int DIV_STEP_W   = 6;

    localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [FRAC_W-1:0]  FULL_WHITE = 17'h10000;

    localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_CENTER_COL    = 3'd1,
        REG_CENTER_ROW    = 3'd2,
        REG_CIRCLE_RADIUS = 3'd3,
        REG_MASK_ENABLE   = 3'd4
    } cmb_reg_t;

    typedef struct packed {
        logic [12:0]        image_width;
        logic signed [13:0] center_col;
        logic signed [13:0] center_row;
        logic [12:0]        circle_radius;
        logic               mask_enable;
    } cmb_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmb_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_R,
        ST_CMP,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT
    } cmb_state_t;

endpackage

// ===== hw/rtl/cmb_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on cmb_pkg.
module cmb_cfg_regs import cmb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CMB_ADDR_W-1:0] paddr,
    input  logic [CMB_DATA_W-1:0] pwdata,
    output logic [CMB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cmb_cfg_t              cfg
);

    cmb_cfg_t cfg_reg;
    cmb_cfg_t cfg_next;
    cmb_reg_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cmb_reg_t'(paddr[CMB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[12:0];
                REG_CENTER_COL:    cfg_next.center_col    = $signed(pwdata[13:0]);
                REG_CENTER_ROW:    cfg_next.center_row    = $signed(pwdata[13:0]);
                REG_CIRCLE_RADIUS: cfg_next.circle_radius = pwdata[12:0];
                REG_MASK_ENABLE:   cfg_next.mask_enable   = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= RST_IMAGE_WIDTH;
            cfg_reg.center_col    <= '0;
            cfg_reg.center_row    <= '0;
            cfg_reg.circle_radius <= '0;
            cfg_reg.mask_enable   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_IMAGE_WIDTH:   prdata = CMB_DATA_W'(cfg_reg.image_width);
            REG_CENTER_COL:    prdata = CMB_DATA_W'(cfg_reg.center_col);
            REG_CENTER_ROW:    prdata = CMB_DATA_W'(cfg_reg.center_row);
            REG_CIRCLE_RADIUS: prdata = CMB_DATA_W'(cfg_reg.circle_radius);
            REG_MASK_ENABLE:   prdata = CMB_DATA_W'(cfg_reg.mask_enable);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/cmb_sq_unit.sv =====
// Shared squaring unit with a registered product.
// Depends on cmb_pkg.
module cmb_sq_unit import cmb_pkg::*; (
    input  logic                 aclk,
    input  logic [SQ_OP_W-1:0]   operand,
    output logic [SQ_PROD_W-1:0] product
);

    logic [SQ_PROD_W-1:0] product_reg;
    logic [SQ_PROD_W-1:0] product_next;

    assign product_next = SQ_PROD_W'(operand) * SQ_PROD_W'(operand);
    assign product      = product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
    end

endmodule

// ===== hw/rtl/cmb_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on cmb_pkg.
module cmb_divider import cmb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output cmb_div_stat_t         stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [DIV_STEP_W-1:0] step_reg,  step_next;
    logic [DIVIDEND_W-1:0] num_reg,   num_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]  den_reg,   den_next;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;

    // Shift in the next dividend bit and try to take the divisor out.
    assign trial = {1'b0, rem_reg, num_reg[DIVIDEND_W-1]} - {2'b00, den_reg};
    assign fits  = !trial[DIVISOR_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = LAST_STEP;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DIVISOR_W-1:0] : {rem_reg[DIVISOR_W-2:0], num_reg[DIVIDEND_W-1]};
            num_next = {num_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

// ===== hw/rtl/circle_masked_brightness.sv =====
// circle_masked_brightness: mean grey level of 8-bit raster pixels, over a circle
// of interest or over the whole image (uses cmb_pkg, cmb_cfg_regs, cmb_sq_unit and
// cmb_divider). The block takes one pixel at a time. A pixel that lies outside the
// circle's bounding square, or any pixel with the mask off, skips the squarer; a
// pixel inside the square has one shared squarer form dx*dx, dy*dy and r*r in turn.
// The pixel flagged frame_last then runs the 48-step serial divider that forms
// floor(sum*65536 / (255*count)), plus any wait for the result register to empty;
// an empty region skips the divider. The user must see that registers are written
// only while no pixel is in work; the block does not enforce it: image_width at 0x00,
// center_col 0x04, center_row 0x08, circle_radius 0x0C, mask_enable 0x10.
module circle_masked_brightness import cmb_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CMB_ADDR_W-1:0] paddr,
    input  logic [CMB_DATA_W-1:0] pwdata,
    output logic [CMB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_pixel_value,
    input  logic                  s_frame_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FRAC_W-1:0]     m_brightness_frac,
    output logic [COUNT_W-1:0]    m_counted_pixels,
    output logic                  m_empty_region
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [WCMP_W-1:0] W_MAX   = WCMP_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0]  ROW_TOP = ROW_W'(MAX_HEIGHT - 1);

    cmb_cfg_t      cfg;
    cmb_div_stat_t div_stat;
    cmb_state_t    state_reg, state_next;

    logic [COL_W-1:0]   col_reg,   col_next;
    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         pix_reg;
    logic               last_reg;
    logic [SQ_OP_W-1:0] adx_reg, ady_reg;
    logic               incl_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               m_valid_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic               empty_reg;

    logic                  accept;
    logic                  div_start;
    logic                  out_load;
    logic                  out_free;
    logic [SQ_OP_W-1:0]    sq_operand;
    logic [SQ_PROD_W-1:0]  sq_product;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  divisor;

    logic signed [DIFF_W-1:0] dx, dy, rad_s, dx_abs, dy_abs;
    logic                     in_square;
    logic [WCMP_W-1:0]        w_eff;
    logic                     col_wrap;
    logic [SUM_W:0]           sum_add;
    logic                     q_over;

    cmb_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cmb_sq_unit u_sq_unit (
        .aclk    (aclk),
        .operand (sq_operand),
        .product (sq_product)
    );

    cmb_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_reg, 16'h0000}),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Offsets from the centre and the bounding-square test
    assign dx        = $signed(DIFF_W'(col_reg)) - DIFF_W'(cfg.center_col);
    assign dy        = $signed(DIFF_W'(row_reg)) - DIFF_W'(cfg.center_row);
    assign rad_s     = $signed(DIFF_W'(cfg.circle_radius));
    assign dx_abs    = dx[DIFF_W-1] ? -dx : dx;
    assign dy_abs    = dy[DIFF_W-1] ? -dy : dy;
    assign in_square = (dx >= -rad_s) && (dx < rad_s) && (dy >= -rad_s) && (dy < rad_s);

    // Clamp the row width into [1, MAX_WIDTH]
    always_comb begin
        if (cfg.image_width == '0) begin
            w_eff = WCMP_W'(1);
        end else if (WCMP_W'(cfg.image_width) > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = WCMP_W'(cfg.image_width);
        end
    end

    assign col_wrap = (WCMP_W'(col_reg) + WCMP_W'(1)) >= w_eff;
    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(pix_reg);
    assign divisor  = {count_reg, 8'h00} - DIVISOR_W'(count_reg);
    assign q_over   = (|quotient[DIVIDEND_W-1:FRAC_W])
                      || (quotient[FRAC_W-1] && (|quotient[FRAC_W-2:0]));
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (cfg.mask_enable && in_square) ? ST_SQ_DX : ST_UPDATE;
                end
            end
            ST_SQ_DX:    state_next = ST_SQ_DY;
            ST_SQ_DY:    state_next = ST_SQ_R;
            ST_SQ_R:     state_next = ST_CMP;
            ST_CMP:      state_next = ST_UPDATE;
            ST_UPDATE:   state_next = last_reg ? ST_DIV_LOAD : ST_IDLE;
            ST_DIV_LOAD: state_next = (count_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        sq_operand = adx_reg;
        case (state_reg)
            ST_IDLE:     s_ready = 1'b1;
            ST_SQ_DX:    sq_operand = adx_reg;
            ST_SQ_DY:    sq_operand = ady_reg;
            ST_SQ_R:     sq_operand = cfg.circle_radius;
            ST_DIV_LOAD: div_start = (count_reg != '0);
            ST_OUT:      out_load = out_free;
            default:     sq_operand = adx_reg;
        endcase
    end

    assign accept = s_valid && s_ready;

    // Position, sum and count
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (state_reg == ST_UPDATE) begin
            if (incl_reg) begin
                sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
            end
            if (col_wrap) begin
                col_next = '0;
                if (row_reg != ROW_TOP) begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end else if (out_load) begin
            col_next   = '0;
            row_next   = '0;
            sum_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pixel latch, distance accumulation and result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg  <= s_pixel_value;
            last_reg <= s_frame_last;
            adx_reg  <= dx_abs[SQ_OP_W-1:0];
            ady_reg  <= dy_abs[SQ_OP_W-1:0];
            incl_reg <= !cfg.mask_enable;
        end
        case (state_reg)
            ST_SQ_DY: dist_reg <= DIST_W'(sq_product);
            ST_SQ_R:  dist_reg <= dist_reg + DIST_W'(sq_product);
            ST_CMP:   incl_reg <= (dist_reg <= DIST_W'(sq_product));
            default:  dist_reg <= dist_reg;
        endcase
        if (out_load) begin
            cnt_out_reg <= count_reg;
            if (count_reg == '0) begin
                frac_reg  <= '0;
                empty_reg <= 1'b1;
            end else begin
                frac_reg  <= q_over ? FULL_WHITE : quotient[FRAC_W-1:0];
                empty_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_brightness_frac = frac_reg;
    assign m_counted_pixels  = cnt_out_reg;
    assign m_empty_region    = empty_reg;

endmodule

// ===== hw/rtl/cmb_checker.sv =====
// Port-level checks for circle_masked_brightness, bound to the top level.
// Depends on cmb_pkg and circle_masked_brightness_assert.svh.
`include "circle_masked_brightness_assert.svh"

module cmb_checker import cmb_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FRAC_W-1:0]  m_brightness_frac,
    input logic [COUNT_W-1:0] m_counted_pixels,
    input logic               m_empty_region
);

    // An empty region reports zero brightness and zero count
    `CMB_ASSERT_NOW(a_empty_zero, m_valid && m_empty_region, (m_brightness_frac == '0) && (m_counted_pixels == '0), "empty region with nonzero result")

    // A filled region has a count and brightness no brighter than full white
    `CMB_ASSERT_NOW(a_filled_range, m_valid && !m_empty_region, (m_counted_pixels != '0) && (m_brightness_frac <= FULL_WHITE), "filled region result out of range")

    // One pixel in work at a time: drop ready after each request
    `CMB_ASSERT_NEXT(a_one_in_work, s_valid && s_ready, !s_ready, "ready held after accepted request")

    // Hold a stalled result
    `CMB_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_brightness_frac) && $stable(m_counted_pixels) && $stable(m_empty_region), "stalled result changed")

endmodule

bind circle_masked_brightness cmb_checker u_cmb_checker (.*);
